// File: rtl/i2cms_pkg.sv
// Shared types, op codes and a helper function for the I2C master pin sequencer.
package i2cms_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COND_ACTIONS  = 5'd4;
    localparam logic [COUNT_W-1:0] WRITE_ACTIONS = 5'd27;
    localparam logic [COUNT_W-1:0] READ_ACTIONS  = 5'd21;

    // write: 8 bits x 3 actions, then ack clock low, release, clock high
    localparam logic [COUNT_W-1:0] WR_BITS_END = 5'd24;
    localparam logic [COUNT_W-1:0] WR_REL      = 5'd25;
    // read: clock low, release, 8 bits x 2 actions, clock low, ack drive, clock high
    localparam logic [COUNT_W-1:0] RD_BITS_END = 5'd18;
    localparam logic [COUNT_W-1:0] RD_ACK      = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx_byte;
        logic              give_nack;
        logic              sda_level;
    } item_t;

    typedef struct packed {
        logic [OP_W-1:0]    command;
        logic [COUNT_W-1:0] action_count;
        logic [1:0]         phase;
        logic [BYTE_W-1:0]  tx_shift;
        logic [BYTE_W-1:0]  rx_shift;
        logic               nack_choice;
        logic               ack_result;
        logic               scl;
        logic               sda;
    } state_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
        logic              rejected;
    } result_t;

    function automatic logic [COUNT_W-1:0] total_actions(input logic [OP_W-1:0] cmd);
        logic [COUNT_W-1:0] n;
        case (cmd)
            OP_START: n = COND_ACTIONS;
            OP_STOP:  n = COND_ACTIONS;
            OP_WRITE: n = WRITE_ACTIONS;
            OP_READ:  n = READ_ACTIONS;
            default:  n = '0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/i2c_master_pin_sequencer_unit.sv
// Top level of the I2C master pin sequencer: input register, step logic, result register.
//
//  port group | dir | tdata (low bit up)                          | tuser
//  s_axis     | in  | tx_byte, give_nack, sda_level, zero pad     | op
//  m_axis     | out | scl_level, sda_drive, busy_res, done_res,   | -
//             |     | rx_byte, ack_seen, rejected, zero pad       |
//
// One beat per clock unless m_axis stalls; an accepted beat waits in the input register
// until the output can advance; that edge updates state and loads the result register.
// Reset puts both pins released, no command pending, output empty.
// A stall on m_axis holds the result; the input register still takes one beat.
module i2c_master_pin_sequencer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tx_byte[7:0], give_nack[8], sda_level[9], zero[15:10]
    input  logic [i2cms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op[2:0]
    input  logic [i2cms_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // scl_level[0], sda_drive[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_seen[12], rejected[13], zero[15:14]
    output logic [i2cms_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic               in_valid_reg;
    i2cms_pkg::item_t   in_item_reg;
    i2cms_pkg::state_t  state_reg;
    i2cms_pkg::state_t  state_next;
    logic               out_valid_reg;
    i2cms_pkg::result_t out_res_reg;
    i2cms_pkg::result_t res_next;
    logic               adv;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || adv;

    i2cms_step u_step (
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{command: i2cms_pkg::OP_TICK, action_count: '0, phase: '0,
                               tx_shift: '0, rx_shift: '0, nack_choice: 1'b0,
                               ack_result: 1'b0, scl: 1'b1, sda: 1'b1};
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (adv)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                    state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.op        <= s_axis_tuser;
            in_item_reg.tx_byte   <= s_axis_tdata[7:0];
            in_item_reg.give_nack <= s_axis_tdata[8];
            in_item_reg.sda_level <= s_axis_tdata[9];
        end
        if (adv && in_valid_reg)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg.rejected, out_res_reg.ack_seen,
                            out_res_reg.rx_byte, out_res_reg.done_res, out_res_reg.busy_res,
                            out_res_reg.sda_drive, out_res_reg.scl_level};

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.done_res |-> !out_res_reg.busy_res)
        else $error("done reported while a command is still pending");

    a_done_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.done_res && out_res_reg.rejected))
        else $error("done and rejected in the same beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (i2cms_pkg::total_actions(state_reg.command) != '0) |->
            (state_reg.action_count < i2cms_pkg::total_actions(state_reg.command)))
        else $error("action count ran past the command length");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && in_valid_reg) |=> $stable(state_reg))
        else $error("state changed without a beat being processed");

endmodule

// File: rtl/i2cms_step.sv
// Single-item update: at most one pin action or command load (a command while busy is rejected), and the result word.
module i2cms_step (
    input  i2cms_pkg::item_t   item,
    input  i2cms_pkg::state_t  cur,
    output i2cms_pkg::state_t  nxt,
    output i2cms_pkg::result_t res
);

    logic [i2cms_pkg::COUNT_W-1:0] total;
    logic [i2cms_pkg::COUNT_W-1:0] cnt_inc;
    logic                          busy;
    logic                          done;
    logic                          rej;
    logic                          is_start;

    assign total    = i2cms_pkg::total_actions(cur.command);
    assign busy     = (total != '0);
    assign cnt_inc  = cur.action_count + 5'd1;
    assign is_start = (cur.command == i2cms_pkg::OP_START);

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        rej  = 1'b0;
        case (item.op)
            i2cms_pkg::OP_TICK:
            begin
                if (busy)
                begin
                    case (cur.command)
                        i2cms_pkg::OP_START, i2cms_pkg::OP_STOP:
                        begin
                            case (cur.action_count)
                                5'd0:    nxt.scl = 1'b0;
                                5'd1:    nxt.sda = is_start;
                                5'd2:    nxt.scl = 1'b1;
                                default: nxt.sda = !is_start;
                            endcase
                        end
                        i2cms_pkg::OP_WRITE:
                        begin
                            if (cur.action_count < i2cms_pkg::WR_BITS_END)
                            begin
                                case (cur.phase)
                                    2'd0:    nxt.scl = 1'b0;
                                    2'd1:
                                    begin
                                        nxt.sda      = cur.tx_shift[i2cms_pkg::BYTE_W-1];
                                        nxt.tx_shift = {cur.tx_shift[i2cms_pkg::BYTE_W-2:0], 1'b0};
                                    end
                                    default: nxt.scl = 1'b1;
                                endcase
                                nxt.phase = (cur.phase == 2'd2) ? 2'd0 : cur.phase + 2'd1;
                            end
                            else if (cur.action_count == i2cms_pkg::WR_BITS_END)
                                nxt.scl = 1'b0;
                            else if (cur.action_count == i2cms_pkg::WR_REL)
                                nxt.sda = 1'b1;
                            else
                            begin
                                nxt.scl        = 1'b1;
                                nxt.ack_result = item.sda_level;
                            end
                        end
                        default:
                        begin
                            if (cur.action_count == 5'd0)
                                nxt.scl = 1'b0;
                            else if (cur.action_count == 5'd1)
                                nxt.sda = 1'b1;
                            else if (cur.action_count < i2cms_pkg::RD_BITS_END)
                            begin
                                if (!cur.action_count[0])
                                    nxt.scl = 1'b0;
                                else
                                begin
                                    nxt.scl      = 1'b1;
                                    nxt.rx_shift = {cur.rx_shift[i2cms_pkg::BYTE_W-2:0],
                                                    item.sda_level};
                                end
                            end
                            else if (cur.action_count == i2cms_pkg::RD_BITS_END)
                                nxt.scl = 1'b0;
                            else if (cur.action_count == i2cms_pkg::RD_ACK)
                                nxt.sda = cur.nack_choice;
                            else
                                nxt.scl = 1'b1;
                        end
                    endcase
                    if (cnt_inc >= total)
                    begin
                        nxt.command      = i2cms_pkg::OP_TICK;
                        nxt.action_count = '0;
                        done             = 1'b1;
                    end
                    else
                        nxt.action_count = cnt_inc;
                end
            end
            i2cms_pkg::OP_START, i2cms_pkg::OP_STOP, i2cms_pkg::OP_WRITE, i2cms_pkg::OP_READ:
            begin
                if (busy)
                    rej = 1'b1;
                else
                begin
                    nxt.command      = item.op;
                    nxt.action_count = '0;
                    nxt.phase        = 2'd0;
                    if (item.op == i2cms_pkg::OP_WRITE)
                        nxt.tx_shift = item.tx_byte;
                    if (item.op == i2cms_pkg::OP_READ)
                        nxt.nack_choice = item.give_nack;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res.scl_level = nxt.scl;
        res.sda_drive = nxt.sda;
        res.busy_res  = (i2cms_pkg::total_actions(nxt.command) != '0);
        res.done_res  = done;
        res.rx_byte   = nxt.rx_shift;
        res.ack_seen  = nxt.ack_result;
        res.rejected  = rej;
    end

endmodule
